>>> hw/rtl/um_pkg.sv
// Shared constants for the universal machine core: default sizes,
// instruction operation codes and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package um_pkg;

  localparam int UmSlotCount = 16;
  localparam int UmSlotWords = 1024;

  localparam logic [3:0] OP_CMOV  = 4'd0;
  localparam logic [3:0] OP_INDEX = 4'd1;
  localparam logic [3:0] OP_AMEND = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_NAND  = 4'd6;
  localparam logic [3:0] OP_HALT  = 4'd7;
  localparam logic [3:0] OP_ALLOC = 4'd8;
  localparam logic [3:0] OP_FREE  = 4'd9;
  localparam logic [3:0] OP_OUT   = 4'd10;
  localparam logic [3:0] OP_IN    = 4'd11;
  localparam logic [3:0] OP_LDPRG = 4'd12;
  localparam logic [3:0] OP_ORTHO = 4'd13;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALTED = 3'd1;
  localparam logic [2:0] ST_DIVZ   = 3'd2;
  localparam logic [2:0] ST_OOB    = 3'd3;
  localparam logic [2:0] ST_NOSLOT = 3'd4;
  localparam logic [2:0] ST_BADOP  = 3'd5;

endpackage
`default_nettype wire

>>> hw/rtl/um_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module um_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/universal_machine_core.sv
// Universal machine core: a 14-operation register machine with array slots.
// Depends on um_pkg and um_ram.
//
// Usage: one input word per item on the slave stream. tuser selects the kind:
// 0 writes a program word into array 0, 1 executes one instruction. Every
// input word gives exactly one output word on the master stream, carrying the
// status, any console output byte, the console-input flag and the new program
// counter. Console input is offered with each execute word and used only by
// the input instruction.
// Steps: a program load answers directly from idle. An execute goes through
// the memory fetch, the register-file reads (one port) and the execute state.
// Index adds a memory read state, multiply a product state, divide a state
// that forms one quotient bit per cycle, allocate a state that zero-fills each
// word, and load program a state that copies each word. The array memory port
// sets these steps. One item is in work at a time.
// Reset clears the registers, the slot table, the free list and the program
// counter; array contents are undefined until written. A stalled receiver
// holds the result in the output register; the next item is taken as soon as
// that register is free or being emptied.
`timescale 1ns / 1ps
`default_nettype none
module universal_machine_core
  import um_pkg::*;
#(
  parameter int SLOT_COUNT = UmSlotCount,
  parameter int SLOT_WORDS = UmSlotWords
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // load_address [9:0], load_data [41:10], console_byte [49:42],
  // console_end [50], zero [55:51]
  input  wire logic [55:0] s_axis_tdata_i,
  // kind [0]: 0 program load, 1 execute
  input  wire logic        s_axis_tuser_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status [2:0], out_valid [3], out_byte [11:4], input_taken [12],
  // program_counter [22:13], zero [23]
  output      logic [23:0] m_axis_tdata_o
);

  localparam int AW    = $clog2(SLOT_COUNT * SLOT_WORDS);
  localparam int OW    = $clog2(SLOT_WORDS);
  localparam int LEN_W = $clog2(SLOT_WORDS + 1);
  localparam int SID_W = $clog2(SLOT_COUNT);
  localparam int QC_W  = $clog2(SLOT_COUNT + 1);
  localparam int PC_W  = ($clog2(SLOT_WORDS + 1) > 10) ? $clog2(SLOT_WORDS + 1) : 10;
  localparam logic [AW-1:0] SW_A = AW'(SLOT_WORDS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_REGS  = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_MEMRD = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FILL  = 4'd7;
  localparam logic [3:0] S_COPY  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic halted_q, halted_d;
  logic [LEN_W-1:0] len_q [SLOT_COUNT];
  logic [LEN_W-1:0] len_d [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] act_q, act_d;
  logic [SID_W-1:0] fq_q [SLOT_COUNT];
  logic [SID_W-1:0] fq_d [SLOT_COUNT];
  logic [SID_W-1:0] qh_q, qh_d;
  logic [QC_W-1:0] qc_q, qc_d;
  logic [QC_W-1:0] fresh_q, fresh_d;
  logic [7:0] rf_vld_q, rf_vld_d;
  logic rf_ok_q;
  logic [1:0] k_q, k_d;

  logic [31:0] instr_q, instr_d, ra_q, ra_d, rb_q, rb_d, rc_q, rc_d;
  logic [7:0] cbyte_q, cbyte_d;
  logic cend_q, cend_d;
  logic [LEN_W-1:0] cnt_q, cnt_d, clen_q, clen_d;
  logic [AW-1:0] base_q, base_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [4:0] dcnt_q, dcnt_d;

  logic mv_q, mv_d;
  logic [22:0] mdat_q, mdat_d;

  logic arr_we;
  logic [AW-1:0] arr_wa, arr_ra;
  logic [31:0] arr_wd, arr_rdata;
  logic rf_we;
  logic [2:0] rf_wa, rf_ra;
  logic [31:0] rf_wd, rf_rdata, rf_val;

  logic s_fire, fin, fin_ov, fin_it;
  logic [2:0] fin_st;
  logic [7:0] fin_ob;

  logic [9:0] ld_addr;
  logic ld_in;
  logic [3:0] op;
  logic [2:0] fa, fb, fc;
  logic [31:0] sel_v, off_v;
  logic sel_in, sel_ok, off_ok;
  logic [SID_W-1:0] sel_i, alloc_id, tail;
  logic [LEN_W-1:0] sel_len;
  logic [AW-1:0] arr_a;
  logic [QC_W:0] tsum;
  logic [32:0] rem_sh;
  logic div_ge;
  logic [31:0] rem_n, quo_n;

  um_ram #(.Width(32), .Depth(SLOT_COUNT * SLOT_WORDS)) u_arr (
    .clk_i   (clk_i),
    .we_i    (arr_we),
    .waddr_i (arr_wa),
    .wdata_i (arr_wd),
    .raddr_i (arr_ra),
    .rdata_o (arr_rdata)
  );

  um_ram #(.Width(32), .Depth(8)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_wa),
    .wdata_i (rf_wd),
    .raddr_i (rf_ra),
    .rdata_o (rf_rdata)
  );

  assign rf_val = rf_ok_q ? rf_rdata : 32'd0;
  assign s_axis_tready_o = (state_q == S_IDLE) && (!mv_q || m_axis_tready_i);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o = {1'b0, mdat_q};

  assign ld_addr = s_axis_tdata_i[9:0];
  assign ld_in = 32'(ld_addr) < 32'(SLOT_WORDS);
  assign op = instr_q[31:28];
  assign fa = instr_q[8:6];
  assign fb = instr_q[5:3];
  assign fc = instr_q[2:0];

  always_comb begin
    case (op)
      OP_AMEND: sel_v = ra_q;
      OP_FREE:  sel_v = rc_q;
      default:  sel_v = rb_q;
    endcase
    off_v = (op == OP_AMEND) ? rb_q : rc_q;
    sel_in = sel_v < 32'(SLOT_COUNT);
    sel_i = sel_v[SID_W-1:0];
    sel_ok = sel_in && act_q[sel_i];
    sel_len = sel_in ? len_q[sel_i] : '0;
    off_ok = off_v < 32'(sel_len);
    arr_a = AW'(sel_i) * SW_A + AW'(off_v[OW-1:0]);
    tsum = (QC_W+1)'(qh_q) + (QC_W+1)'(qc_q);
    tail = (tsum >= (QC_W+1)'(SLOT_COUNT)) ? SID_W'(tsum - (QC_W+1)'(SLOT_COUNT))
                                            : SID_W'(tsum);
    rem_sh = {rem_q, quo_q[31]};
    div_ge = rem_sh >= {1'b0, den_q};
    rem_n = div_ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
    quo_n = {quo_q[30:0], div_ge};
  end

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    halted_d = halted_q;
    len_d = len_q;
    act_d = act_q;
    fq_d = fq_q;
    qh_d = qh_q;
    qc_d = qc_q;
    fresh_d = fresh_q;
    rf_vld_d = rf_vld_q;
    k_d = k_q;
    instr_d = instr_q;
    ra_d = ra_q;
    rb_d = rb_q;
    rc_d = rc_q;
    cbyte_d = cbyte_q;
    cend_d = cend_q;
    cnt_d = cnt_q;
    clen_d = clen_q;
    base_d = base_q;
    prod_d = prod_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    dcnt_d = dcnt_q;
    arr_we = 1'b0;
    arr_wa = '0;
    arr_wd = '0;
    arr_ra = '0;
    rf_we = 1'b0;
    rf_wa = '0;
    rf_wd = '0;
    rf_ra = '0;
    alloc_id = '0;
    fin = 1'b0;
    fin_st = ST_OK;
    fin_ov = 1'b0;
    fin_ob = '0;
    fin_it = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          cbyte_d = s_axis_tdata_i[49:42];
          cend_d = s_axis_tdata_i[50];
          if (!s_axis_tuser_i) begin
            if (ld_in) begin
              arr_we = 1'b1;
              arr_wa = AW'(ld_addr);
              arr_wd = s_axis_tdata_i[41:10];
              if (32'(len_q[0]) <= 32'(ld_addr)) begin
                len_d[0] = LEN_W'(ld_addr) + LEN_W'(1);
              end
            end
            fin = 1'b1;
            fin_st = halted_q ? ST_HALTED : ST_OK;
          end else if (halted_q) begin
            fin = 1'b1;
            fin_st = ST_HALTED;
          end else if (32'(pc_q) >= 32'(len_q[0])) begin
            fin = 1'b1;
            fin_st = ST_OOB;
            halted_d = 1'b1;
          end else begin
            arr_ra = AW'(pc_q);
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        instr_d = arr_rdata;
        k_d = 2'd0;
        state_d = S_REGS;
      end
      S_REGS: begin
        case (k_q)
          2'd0: rf_ra = fa;
          2'd1: rf_ra = fb;
          default: rf_ra = fc;
        endcase
        k_d = k_q + 2'd1;
        case (k_q)
          2'd1: ra_d = rf_val;
          2'd2: rb_d = rf_val;
          2'd3: begin
            rc_d = rf_val;
            state_d = S_EXEC;
          end
          default: ;
        endcase
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (op)
          OP_CMOV: begin
            rf_we = rc_q != 32'd0;
            rf_wa = fa;
            rf_wd = rb_q;
            fin = 1'b1;
            pc_d = pc_q + PC_W'(1);
          end
          OP_INDEX: begin
            if (!sel_ok || !off_ok) begin
              fin = 1'b1;
              fin_st = ST_OOB;
              halted_d = 1'b1;
            end else begin
              arr_ra = arr_a;
              state_d = S_MEMRD;
            end
          end
          OP_AMEND: begin
            fin = 1'b1;
            if (!sel_ok || !off_ok) begin
              fin_st = ST_OOB;
              halted_d = 1'b1;
            end else begin
              arr_we = 1'b1;
              arr_wa = arr_a;
              arr_wd = rc_q;
              pc_d = pc_q + PC_W'(1);
            end
          end
          OP_ADD, OP_NAND: begin
            rf_we = 1'b1;
            rf_wa = fa;
            rf_wd = (op == OP_ADD) ? rb_q + rc_q : ~(rb_q & rc_q);
            fin = 1'b1;
            pc_d = pc_q + PC_W'(1);
          end
          OP_MUL: begin
            prod_d = rb_q * rc_q;
            state_d = S_MUL;
          end
          OP_DIV: begin
            if (rc_q == 32'd0) begin
              fin = 1'b1;
              fin_st = ST_DIVZ;
              halted_d = 1'b1;
            end else begin
              rem_d = '0;
              quo_d = rb_q;
              den_d = rc_q;
              dcnt_d = 5'd31;
              state_d = S_DIV;
            end
          end
          OP_HALT: begin
            fin = 1'b1;
            fin_st = ST_HALTED;
            halted_d = 1'b1;
          end
          OP_ALLOC: begin
            if (rc_q > 32'(SLOT_WORDS)) begin
              fin = 1'b1;
              fin_st = ST_OOB;
              halted_d = 1'b1;
            end else if (qc_q == '0 && fresh_q >= QC_W'(SLOT_COUNT)) begin
              fin = 1'b1;
              fin_st = ST_NOSLOT;
              halted_d = 1'b1;
            end else begin
              if (qc_q != '0) begin
                alloc_id = fq_q[qh_q];
                qh_d = (qh_q == SID_W'(SLOT_COUNT - 1)) ? '0 : qh_q + SID_W'(1);
                qc_d = qc_q - QC_W'(1);
              end else begin
                alloc_id = SID_W'(fresh_q);
                fresh_d = fresh_q + QC_W'(1);
              end
              act_d[alloc_id] = 1'b1;
              len_d[alloc_id] = LEN_W'(rc_q);
              rf_we = 1'b1;
              rf_wa = fb;
              rf_wd = 32'(alloc_id);
              base_d = AW'(alloc_id) * SW_A;
              clen_d = LEN_W'(rc_q);
              cnt_d = '0;
              if (rc_q == 32'd0) begin
                fin = 1'b1;
                pc_d = pc_q + PC_W'(1);
              end else begin
                state_d = S_FILL;
              end
            end
          end
          OP_FREE: begin
            fin = 1'b1;
            if (rc_q == 32'd0 || !sel_ok || qc_q >= QC_W'(SLOT_COUNT)) begin
              fin_st = ST_OOB;
              halted_d = 1'b1;
            end else begin
              act_d[sel_i] = 1'b0;
              len_d[sel_i] = '0;
              fq_d[tail] = sel_i;
              qc_d = qc_q + QC_W'(1);
              pc_d = pc_q + PC_W'(1);
            end
          end
          OP_OUT: begin
            fin = 1'b1;
            fin_ov = 1'b1;
            fin_ob = rc_q[7:0];
            pc_d = pc_q + PC_W'(1);
          end
          OP_IN: begin
            rf_we = 1'b1;
            rf_wa = fc;
            rf_wd = cend_q ? 32'hffff_ffff : 32'(cbyte_q);
            fin = 1'b1;
            fin_it = 1'b1;
            pc_d = pc_q + PC_W'(1);
          end
          OP_LDPRG: begin
            if (!sel_ok || !off_ok) begin
              fin = 1'b1;
              fin_st = ST_OOB;
              halted_d = 1'b1;
            end else begin
              pc_d = PC_W'(rc_q);
              if (sel_i != '0) begin
                len_d[0] = sel_len;
              end
              base_d = AW'(sel_i) * SW_A;
              clen_d = sel_len;
              cnt_d = '0;
              if (sel_i != '0 && sel_len != '0) begin
                state_d = S_COPY;
              end else begin
                fin = 1'b1;
              end
            end
          end
          OP_ORTHO: begin
            rf_we = 1'b1;
            rf_wa = instr_q[27:25];
            rf_wd = {7'd0, instr_q[24:0]};
            fin = 1'b1;
            pc_d = pc_q + PC_W'(1);
          end
          default: begin
            fin = 1'b1;
            fin_st = ST_BADOP;
            halted_d = 1'b1;
          end
        endcase
      end
      S_MEMRD: begin
        rf_we = 1'b1;
        rf_wa = fa;
        rf_wd = arr_rdata;
        fin = 1'b1;
        pc_d = pc_q + PC_W'(1);
        state_d = S_IDLE;
      end
      S_MUL: begin
        rf_we = 1'b1;
        rf_wa = fa;
        rf_wd = prod_q;
        fin = 1'b1;
        pc_d = pc_q + PC_W'(1);
        state_d = S_IDLE;
      end
      S_DIV: begin
        rem_d = rem_n;
        quo_d = quo_n;
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == 5'd0) begin
          rf_we = 1'b1;
          rf_wa = fa;
          rf_wd = quo_n;
          fin = 1'b1;
          pc_d = pc_q + PC_W'(1);
          state_d = S_IDLE;
        end
      end
      S_FILL: begin
        arr_we = 1'b1;
        arr_wa = base_q + AW'(cnt_q);
        arr_wd = '0;
        cnt_d = cnt_q + LEN_W'(1);
        if (cnt_q == clen_q - LEN_W'(1)) begin
          fin = 1'b1;
          pc_d = pc_q + PC_W'(1);
          state_d = S_IDLE;
        end
      end
      S_COPY: begin
        arr_ra = base_q + AW'(cnt_q);
        if (cnt_q != '0) begin
          arr_we = 1'b1;
          arr_wa = AW'(cnt_q - LEN_W'(1));
          arr_wd = arr_rdata;
        end
        cnt_d = cnt_q + LEN_W'(1);
        if (cnt_q == clen_q) begin
          fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (rf_we) begin
      rf_vld_d[rf_wa] = 1'b1;
    end

    mdat_d = mdat_q;
    if (fin) begin
      mv_d = 1'b1;
      mdat_d = {pc_d[9:0], fin_it, fin_ob, fin_ov, fin_st};
    end else if (m_axis_tready_i) begin
      mv_d = 1'b0;
    end else begin
      mv_d = mv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      halted_q <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        len_q[i] <= '0;
      end
      act_q <= SLOT_COUNT'(1);
      qh_q <= '0;
      qc_q <= '0;
      fresh_q <= QC_W'(1);
      rf_vld_q <= '0;
      rf_ok_q <= 1'b0;
      k_q <= '0;
      mv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      halted_q <= halted_d;
      len_q <= len_d;
      act_q <= act_d;
      qh_q <= qh_d;
      qc_q <= qc_d;
      fresh_q <= fresh_d;
      rf_vld_q <= rf_vld_d;
      rf_ok_q <= rf_vld_q[rf_ra];
      k_q <= k_d;
      mv_q <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fq_q <= fq_d;
    instr_q <= instr_d;
    ra_q <= ra_d;
    rb_q <= rb_d;
    rc_q <= rc_d;
    cbyte_q <= cbyte_d;
    cend_q <= cend_d;
    cnt_q <= cnt_d;
    clen_q <= clen_d;
    base_q <= base_d;
    prod_q <= prod_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    dcnt_q <= dcnt_d;
    mdat_q <= mdat_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == S_IDLE)
    else $error("input taken outside idle");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qc_q <= QC_W'(SLOT_COUNT) && fresh_q <= QC_W'(SLOT_COUNT))
    else $error("free list or fresh slot counter overflow");

  a_halted_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser_i && halted_q) |=>
      (m_axis_tvalid_o && m_axis_tdata_o[2:0] == ST_HALTED))
    else $error("step while halted did not report halted");

  a_slot0_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q[0])
    else $error("program slot lost");

endmodule
`default_nettype wire
